// ===== rtl/scqf_pkg.sv =====
// ----------------------------------------------------------------------------
// scqf_pkg: shared types and constants of the soft-clip quality filter
// record passed from the accumulating front to the decision back end, and
// the decision result
// ----------------------------------------------------------------------------
package scqf_pkg;

    localparam int unsigned SUM_W   = 18;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned QUAL_W  = 8;
    localparam int unsigned RATIO_W = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

    localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd6;

    // per-read decision request: final sums and region lengths
    typedef struct packed {
        logic [SUM_W-1:0] left_sum;
        logic [SUM_W-1:0] middle_sum;
        logic [SUM_W-1:0] right_sum;
        logic [LEN_W-1:0] left_len;
        logic [LEN_W-1:0] mid_len;
        logic [LEN_W-1:0] right_len;
    } rec_t;

    typedef struct packed {
        logic read_passes;
        logic left_kept;
        logic right_kept;
    } res_t;

    // handshake between a producer and a queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/scqf_fifo.sv =====
// ----------------------------------------------------------------------------
// scqf_fifo: small register queue
// first-in first-out storage with occupancy count, used between the stages
// ----------------------------------------------------------------------------
module scqf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [WIDTH-1:0]            push_data,
    input  logic                        pop,
    output logic [WIDTH-1:0]            pop_data,
    output scqf_pkg::q_status_t         status
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CntW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy never runs past the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntW'(DEPTH))
        else $error("scqf_fifo: count beyond depth");

    // a lone pop takes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("scqf_fifo: pop did not reduce count");

endmodule

// ===== rtl/scqf_front.sv =====
// ----------------------------------------------------------------------------
// scqf_front: quality accumulation front end
// classifies each quality byte into left clip, middle or right clip and keeps
// saturating sums; on the last byte it issues one decision record
// ----------------------------------------------------------------------------
module scqf_front #(
    parameter int unsigned MAX_READ_LEN = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [scqf_pkg::QUAL_W-1:0]      qual,
    input  logic [scqf_pkg::LEN_W-1:0]       read_length,
    input  logic [scqf_pkg::LEN_W-1:0]       clip_left,
    input  logic [scqf_pkg::LEN_W-1:0]       clip_right,
    input  logic                             last_base,
    output logic                             rec_push,
    output scqf_pkg::rec_t                   rec
);

    localparam int unsigned LW = scqf_pkg::LEN_W;
    localparam int unsigned SW = scqf_pkg::SUM_W;
    localparam logic [LW-1:0] LenCap =
        (MAX_READ_LEN > ((1 << LW) - 1)) ? {LW{1'b1}} : LW'(MAX_READ_LEN);

    logic [LW-1:0] pos_reg, pos_next;
    logic [SW-1:0] lsum_reg, lsum_next;
    logic [SW-1:0] msum_reg, msum_next;
    logic [SW-1:0] rsum_reg, rsum_next;
    logic [LW-1:0] n_len, l_len, r_len, m_len, rest_len, lm_end;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                              input logic [scqf_pkg::QUAL_W-1:0] q);
        logic [SW:0] t;
        t = {1'b0, s} + (SW+1)'(q);
        return t[SW] ? scqf_pkg::SUM_MAX : t[SW-1:0];
    endfunction

    // region bounds, left clip first
    always_comb
    begin
        n_len    = (read_length > LenCap) ? LenCap : read_length;
        l_len    = (clip_left < n_len) ? clip_left : n_len;
        rest_len = n_len - l_len;
        r_len    = (clip_right < rest_len) ? clip_right : rest_len;
        m_len    = rest_len - r_len;
        lm_end   = l_len + m_len;
    end

    always_comb
    begin
        lsum_next = lsum_reg;
        msum_next = msum_reg;
        rsum_next = rsum_reg;
        if (pos_reg < l_len)
        begin
            lsum_next = sat_add(lsum_reg, qual);
        end
        else if (pos_reg < lm_end)
        begin
            msum_next = sat_add(msum_reg, qual);
        end
        else if (pos_reg < n_len)
        begin
            rsum_next = sat_add(rsum_reg, qual);
        end
        pos_next = (pos_reg < scqf_pkg::POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    end

    assign rec_push        = accept && last_base;
    assign rec.left_sum    = lsum_next;
    assign rec.middle_sum  = msum_next;
    assign rec.right_sum   = rsum_next;
    assign rec.left_len    = l_len;
    assign rec.mid_len     = m_len;
    assign rec.right_len   = r_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            lsum_reg <= '0;
            msum_reg <= '0;
            rsum_reg <= '0;
        end
        else if (accept)
        begin
            if (last_base)
            begin
                pos_reg  <= '0;
                lsum_reg <= '0;
                msum_reg <= '0;
                rsum_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                lsum_reg <= lsum_next;
                msum_reg <= msum_next;
                rsum_reg <= rsum_next;
            end
        end
    end

endmodule

// ===== rtl/scqf_back.sv =====
// ----------------------------------------------------------------------------
// scqf_back: clip decision sequencer
// takes one record, forms both cross products over two multiply steps,
// compares and writes one result into the output queue
// ----------------------------------------------------------------------------
module scqf_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [scqf_pkg::RATIO_W-1:0]      ratio_tenths,
    input  scqf_pkg::rec_t                    rec,
    input  scqf_pkg::q_status_t               rec_status,
    output logic                              rec_pop,
    input  scqf_pkg::q_status_t               res_status,
    output logic                              res_push,
    output scqf_pkg::res_t                    res
);

    localparam int unsigned SW = scqf_pkg::SUM_W;
    localparam int unsigned LW = scqf_pkg::LEN_W;
    localparam int unsigned P1W = SW + LW;                     // clip sum * middle len
    localparam int unsigned QW  = SW + scqf_pkg::RATIO_W;      // ratio * middle sum
    localparam int unsigned XW  = P1W + 4;                     // times ten / times len

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL1 = 2'd1;
    localparam logic [1:0] PH_MUL2 = 2'd2;
    localparam logic [1:0] PH_CMP  = 2'd3;

    logic [1:0]      phase_reg, phase_next;
    scqf_pkg::rec_t  rec_reg;
    logic [P1W-1:0]  pl_reg, pr_reg;
    logic [QW-1:0]   q_reg;
    logic [XW-1:0]   lhs_l_reg, rhs_l_reg, lhs_r_reg, rhs_r_reg;
    logic            start;
    logic            keep_l, keep_r;

    assign start   = (phase_reg == PH_IDLE) && !rec_status.empty && !res_status.full;
    assign rec_pop = start;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: phase_next = start ? PH_MUL1 : PH_IDLE;
            PH_MUL1: phase_next = PH_MUL2;
            PH_MUL2: phase_next = PH_CMP;
            PH_CMP:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rec_reg <= rec;
        end
        if (phase_reg == PH_MUL1)
        begin
            pl_reg <= P1W'(rec_reg.left_sum) * P1W'(rec_reg.mid_len);
            pr_reg <= P1W'(rec_reg.right_sum) * P1W'(rec_reg.mid_len);
            q_reg  <= QW'(ratio_tenths) * QW'(rec_reg.middle_sum);
        end
        if (phase_reg == PH_MUL2)
        begin
            // times ten as shift and add
            lhs_l_reg <= XW'({pl_reg, 3'b000}) + XW'({2'b00, pl_reg, 1'b0});
            lhs_r_reg <= XW'({pr_reg, 3'b000}) + XW'({2'b00, pr_reg, 1'b0});
            rhs_l_reg <= XW'(q_reg) * XW'(rec_reg.left_len);
            rhs_r_reg <= XW'(q_reg) * XW'(rec_reg.right_len);
        end
    end

    // empty clip never kept, empty middle keeps any clip
    always_comb
    begin
        priority if (rec_reg.left_len == '0)
            keep_l = 1'b0;
        else if (rec_reg.mid_len == '0)
            keep_l = 1'b1;
        else
            keep_l = (lhs_l_reg >= rhs_l_reg);
        priority if (rec_reg.right_len == '0)
            keep_r = 1'b0;
        else if (rec_reg.mid_len == '0)
            keep_r = 1'b1;
        else
            keep_r = (lhs_r_reg >= rhs_r_reg);
    end

    assign res_push        = (phase_reg == PH_CMP);
    assign res.read_passes = keep_l || keep_r;
    assign res.left_kept   = keep_l;
    assign res.right_kept  = keep_r;

    // room was checked at start and only this sequencer fills the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CMP) |-> !res_status.full)
        else $error("scqf_back: result queue full at write");

    // a started record always runs the full sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (phase_reg == PH_MUL1) ##1 (phase_reg == PH_MUL2) ##1 (phase_reg == PH_CMP))
        else $error("scqf_back: sequence broken");

endmodule

// ===== rtl/soft_clip_quality_filter.sv =====
// ----------------------------------------------------------------------------
// soft_clip_quality_filter: soft-clip quality test for one read
// accumulates per-region quality sums and decides which soft clips survive
// ----------------------------------------------------------------------------
// One quality byte is taken per cycle, in read order, with the read length
// and clip lengths held constant across the read; the byte flagged last_base
// closes the read and produces exactly one result (read_passes, left_kept,
// right_kept) on the result queue, other bytes produce none. Bytes stream at
// one per cycle as long as the four-deep record queue has room; full rises
// only when four closed reads wait for a decision. Each decision runs through
// the back-end sequencer (record load, two registered multiply steps, compare),
// and a new record is taken only after the last compare and while the result
// queue has room. ratio_tenths resets to 6 and is written through cfg_we /
// cfg_data; the user writes it only while the block is idle (not enforced).
module soft_clip_quality_filter #(
    parameter int unsigned MAX_READ_LEN = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [scqf_pkg::RATIO_W-1:0]      cfg_data,
    // quality byte requests
    input  logic                              push,
    output logic                              full,
    input  logic [scqf_pkg::QUAL_W-1:0]       qual,
    input  logic [scqf_pkg::LEN_W-1:0]        read_length,
    input  logic [scqf_pkg::LEN_W-1:0]        clip_left,
    input  logic [scqf_pkg::LEN_W-1:0]        clip_right,
    input  logic                              last_base,
    // result requests
    output logic                              empty,
    input  logic                              pop,
    output logic                              read_passes,
    output logic                              left_kept,
    output logic                              right_kept
);

    localparam int unsigned RecDepth = 4;
    localparam int unsigned ResDepth = 2;

    logic [scqf_pkg::RATIO_W-1:0] ratio_reg;

    logic                 in_accept;
    logic                 rec_push, rec_pop;
    scqf_pkg::rec_t       rec_in, rec_out;
    scqf_pkg::q_status_t  rec_status, res_status;
    logic                 res_push;
    scqf_pkg::res_t       res_in, res_out;

    // ratio register; the user writes it only while idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= scqf_pkg::RATIO_RESET;
        end
        else if (cfg_we)
        begin
            ratio_reg <= cfg_data;
        end
    end

    // input side stalls only on a full record queue
    assign full      = rec_status.full;
    assign in_accept = push && !rec_status.full;

    // front: classify and sum each byte
    scqf_front #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .qual        (qual),
        .read_length (read_length),
        .clip_left   (clip_left),
        .clip_right  (clip_right),
        .last_base   (last_base),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    // decouples the byte stream from the decision sequencer
    scqf_fifo #(
        .WIDTH ($bits(scqf_pkg::rec_t)),
        .DEPTH (RecDepth)
    ) u_rec_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_in),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .status    (rec_status)
    );

    // back: cross-multiplied mean comparison
    scqf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ratio_tenths (ratio_reg),
        .rec          (rec_out),
        .rec_status   (rec_status),
        .rec_pop      (rec_pop),
        .res_status   (res_status),
        .res_push     (res_push),
        .res          (res_in)
    );

    // result queue, oldest result shown while not empty
    scqf_fifo #(
        .WIDTH ($bits(scqf_pkg::res_t)),
        .DEPTH (ResDepth)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .pop       (pop),
        .pop_data  (res_out),
        .status    (res_status)
    );

    assign empty       = res_status.empty;
    assign read_passes = res_out.read_passes;
    assign left_kept   = res_out.left_kept;
    assign right_kept  = res_out.right_kept;

endmodule
